// ===== hdl/pts_pkg.sv =====
// Shared types and codes for the priority thread scheduler.
// No dependencies; every other file of the scheduler depends on this package.
`default_nettype none

package pts_pkg;

	localparam int THREADS  = 16;
	localparam int TID_W    = $clog2(THREADS);
	localparam int THREAD_W = 4;
	localparam int PRI_W    = 8;
	localparam int KIND_W   = 3;
	localparam int ST_W     = 3;

	typedef logic [TID_W-1:0]    tid_t;
	typedef logic [THREAD_W-1:0] thread_t;
	typedef logic [PRI_W-1:0]    pri_t;
	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [ST_W-1:0]     tstate_t;
	typedef logic [THREADS-1:0]  tmask_t;

	// Event codes.
	localparam kind_t K_NOTIFY   = 3'd0;
	localparam kind_t K_SCHEDULE = 3'd1;
	localparam kind_t K_STOP     = 3'd2;
	localparam kind_t K_CLEANUP  = 3'd3;
	localparam kind_t K_REPRIO   = 3'd4;
	localparam kind_t K_YIELDED  = 3'd5;
	localparam kind_t K_BLOCKED  = 3'd6;
	localparam kind_t K_UNBLOCK  = 3'd7;

	// Thread state codes.
	localparam tstate_t ST_STOPPED     = 3'd0;
	localparam tstate_t ST_PAUSED      = 3'd1;
	localparam tstate_t ST_RUNNING     = 3'd2;
	localparam tstate_t ST_BLK_STOPPED = 3'd3;
	localparam tstate_t ST_BLK_PAUSED  = 3'd4;

	typedef struct packed {
		logic any;
		tid_t best;
	} pick_t;

	typedef struct packed {
		logic    resume_valid;
		thread_t resume_thread;
		logic    deschedule_valid;
		thread_t deschedule_thread;
		logic    running_valid;
		thread_t run_thread;
		logic    must_wait;
		logic    fault;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/pts_if.sv =====
// Handshake channels of the scheduler: event words in, result words out.
// Depends on pts_pkg for the field types.
`default_nettype none

interface pts_evt_if;
	logic           valid;
	logic           ready;
	pts_pkg::kind_t  kind;
	pts_pkg::thread_t thread;
	pts_pkg::pri_t   new_priority;

	modport source(output valid, kind, thread, new_priority, input ready);
	modport sink(input valid, kind, thread, new_priority, output ready);
endinterface

interface pts_res_if;
	logic             valid;
	logic             ready;
	logic             resume_valid;
	pts_pkg::thread_t resume_thread;
	logic             deschedule_valid;
	pts_pkg::thread_t deschedule_thread;
	logic             running_valid;
	pts_pkg::thread_t run_thread;
	logic             must_wait;
	logic             fault;

	modport source(output valid, resume_valid, resume_thread, deschedule_valid,
		deschedule_thread, running_valid, run_thread, must_wait, fault,
		input ready);
	modport sink(input valid, resume_valid, resume_thread, deschedule_valid,
		deschedule_thread, running_valid, run_thread, must_wait, fault,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/pts_pick.sv =====
// Best-thread selector: highest priority among ready threads, oldest first on ties.
// Purely combinational; depends on pts_pkg.
`default_nettype none

module pts_pick (
	input  var pts_pkg::tmask_t                        ready,
	input  var pts_pkg::pri_t [pts_pkg::THREADS-1:0]   pri,
	input  var pts_pkg::tmask_t [pts_pkg::THREADS-1:0] order,
	output pts_pkg::pick_t                             pick
);
	import pts_pkg::*;

	tmask_t is_top;
	tmask_t oldest;

	// A thread is a candidate when no ready thread has a strictly higher priority.
	always_comb begin
		for (int i = 0; i < THREADS; i++) begin
			is_top[i] = ready[i];
			for (int j = 0; j < THREADS; j++) begin
				if (ready[j] && (pri[j] > pri[i])) begin
					is_top[i] = 1'b0;
				end
			end
		end
	end

	// The oldest candidate has its order bit set for every other candidate.
	always_comb begin
		for (int i = 0; i < THREADS; i++) begin
			oldest[i] = is_top[i] & (&(order[i] | ~is_top | (tmask_t'(1) << i)));
		end
	end

	always_comb begin
		pick.any  = |ready;
		pick.best = '0;
		for (int i = THREADS - 1; i >= 0; i--) begin
			if (is_top[i]) begin
				pick.best = tid_t'(i);
			end
		end
		if (|oldest) begin
			for (int i = THREADS - 1; i >= 0; i--) begin
				if (oldest[i]) begin
					pick.best = tid_t'(i);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pts_core.sv =====
// Thread table, event decode and selection of the scheduler.
// Depends on pts_pkg and instantiates pts_pick.
`default_nettype none

module pts_core (
	input  var logic             clk,
	input  var logic             arst_n,
	input  var logic             fire,
	input  var pts_pkg::kind_t   kind,
	input  var pts_pkg::thread_t thread,
	input  var pts_pkg::pri_t    new_priority,
	output pts_pkg::result_t     result
);
	import pts_pkg::*;

	tstate_t [THREADS-1:0] st_q,  st_ev,  st_n;
	pri_t    [THREADS-1:0] pri_q, pri_n;
	tmask_t  [THREADS-1:0] ord_q, ord_n;
	tmask_t                rdy_q, rdy_n;
	tid_t                  cur_q, cur_n;
	logic                  curv_q, curv_n;

	logic   in_range;
	kind_t  k;
	tid_t   t;
	logic   mk;
	logic   clean;
	logic   fault;
	logic   cur_running;
	pick_t  pick;

	assign in_range = (32'(thread) < THREADS);
	assign k        = in_range ? kind : K_NOTIFY;
	assign t        = tid_t'(thread);

	// Apply the event to the thread table.
	always_comb begin
		st_ev = st_q;
		rdy_n = rdy_q;
		pri_n = pri_q;
		ord_n = ord_q;
		mk    = 1'b0;
		clean = 1'b0;
		fault = 1'b0;
		unique case (k)
			K_SCHEDULE: begin
				if (st_q[t] == ST_BLK_STOPPED) begin
					st_ev[t] = ST_BLK_PAUSED;
				end else begin
					st_ev[t] = ST_PAUSED;
					mk       = 1'b1;
				end
			end
			K_STOP: begin
				rdy_n[t] = 1'b0;
				st_ev[t] = (st_q[t] == ST_BLK_PAUSED) ? ST_BLK_STOPPED : ST_STOPPED;
			end
			K_CLEANUP: begin
				rdy_n[t] = 1'b0;
				clean    = 1'b1;
			end
			K_REPRIO: begin
				pri_n[t] = new_priority;
				mk       = rdy_q[t];
			end
			K_YIELDED: begin
				mk       = rdy_q[t];
				st_ev[t] = ST_PAUSED;
			end
			K_BLOCKED: begin
				rdy_n[t] = 1'b0;
				if (st_q[t] == ST_STOPPED) begin
					st_ev[t] = ST_BLK_STOPPED;
				end else if (st_q[t] == ST_RUNNING) begin
					st_ev[t] = ST_BLK_PAUSED;
				end else begin
					fault = 1'b1;
				end
			end
			K_UNBLOCK: begin
				if (st_q[t] == ST_BLK_STOPPED) begin
					st_ev[t] = ST_STOPPED;
				end else if (st_q[t] == ST_BLK_PAUSED) begin
					st_ev[t] = ST_PAUSED;
					mk       = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// Making a thread ready puts it behind every other thread.
		if (mk) begin
			for (int j = 0; j < THREADS; j++) begin
				ord_n[j][t] = 1'b1;
			end
			ord_n[t] = '0;
			rdy_n[t] = 1'b1;
		end
	end

	pts_pick u_pick (
		.ready(rdy_n),
		.pri  (pri_n),
		.order(ord_n),
		.pick (pick)
	);

	// Pick the running thread on the updated table.
	always_comb begin
		tid_t cur_e;
		logic curv_e;
		cur_e  = cur_q;
		curv_e = curv_q;
		if (clean && curv_q && (cur_q == t)) begin
			if (pick.any) begin
				cur_e = pick.best;
			end else begin
				curv_e = 1'b0;
			end
		end
		st_n        = st_ev;
		cur_n       = cur_e;
		curv_n      = curv_e;
		cur_running = curv_e && (st_ev[cur_e] == ST_RUNNING);
		result      = '0;
		result.fault = fault;
		if (pick.any) begin
			if (curv_e && (cur_e == pick.best)) begin
				if (!cur_running) begin
					st_n[pick.best]      = ST_RUNNING;
					result.resume_valid  = 1'b1;
					result.resume_thread = THREAD_W'(pick.best);
				end
			end else if (cur_running) begin
				result.must_wait = 1'b1;
			end else begin
				st_n[pick.best]      = ST_RUNNING;
				result.resume_valid  = 1'b1;
				result.resume_thread = THREAD_W'(pick.best);
				if (curv_e) begin
					result.deschedule_valid  = 1'b1;
					result.deschedule_thread = THREAD_W'(cur_e);
				end
				cur_n  = pick.best;
				curv_n = 1'b1;
			end
		end else begin
			curv_n = 1'b0;
		end
		result.running_valid = curv_n;
		result.run_thread    = curv_n ? THREAD_W'(cur_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			pri_q  <= '0;
			ord_q  <= '0;
			rdy_q  <= '0;
			cur_q  <= '0;
			curv_q <= 1'b0;
		end else if (fire) begin
			st_q   <= st_n;
			pri_q  <= pri_n;
			ord_q  <= ord_n;
			rdy_q  <= rdy_n;
			cur_q  <= cur_n;
			curv_q <= curv_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/priority_thread_scheduler.sv =====
// Priority thread scheduler: one event word in, one result word out.
// A word is staged on acceptance; its result is registered once the output slot frees.
// Throughput: one event per cycle unless res stalls; update and pick are combinational.
// Reset: asynchronous; all threads stopped, priority zero, none ready, no current thread.
// Depends on pts_pkg, pts_if, pts_core and pts_pick.
`default_nettype none

module priority_thread_scheduler (
	input  var logic clk,
	input  var logic arst_n,
	pts_evt_if.sink  evt,
	pts_res_if.source res
);
	import pts_pkg::*;

	logic    valid_s1;
	kind_t   kind_s1;
	thread_t thread_s1;
	pri_t    pri_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t core_res;
	logic    adv;

	// The staged word moves on when the result register is free or being emptied.
	assign adv       = valid_s1 && (!out_valid_q || res.ready);
	assign evt.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= (evt.valid && evt.ready) || (valid_s1 && !adv);
			out_valid_q <= adv || (out_valid_q && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			kind_s1   <= evt.kind;
			thread_s1 <= evt.thread;
			pri_s1    <= evt.new_priority;
		end
		if (adv) begin
			out_q <= core_res;
		end
	end

	pts_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv),
		.kind        (kind_s1),
		.thread      (thread_s1),
		.new_priority(pri_s1),
		.result      (core_res)
	);

	assign res.valid             = out_valid_q;
	assign res.resume_valid      = out_q.resume_valid;
	assign res.resume_thread     = out_q.resume_thread;
	assign res.deschedule_valid  = out_q.deschedule_valid;
	assign res.deschedule_thread = out_q.deschedule_thread;
	assign res.running_valid     = out_q.running_valid;
	assign res.run_thread        = out_q.run_thread;
	assign res.must_wait         = out_q.must_wait;
	assign res.fault             = out_q.fault;

endmodule

`default_nettype wire
